// ===== hdl/srhm_pkg.sv =====
// ----------------------------------------------------------------------------
// srhm_pkg
// Shared types and codes for the scan rate health monitor.
// ----------------------------------------------------------------------------
package srhm_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Input operation codes.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_FRAME   = 3'd1;
    localparam logic [2:0] OP_FRONT   = 3'd2;
    localparam logic [2:0] OP_BACK    = 3'd3;
    localparam logic [2:0] OP_COMMAND = 3'd4;

    // Unit state codes.
    localparam logic [1:0] UNIT_OFF      = 2'd0;
    localparam logic [1:0] UNIT_ON       = 2'd1;
    localparam logic [1:0] UNIT_STARTING = 2'd2;
    localparam logic [1:0] UNIT_STOPPING = 2'd3;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_LOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_FLOOR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GOOD_NEEDED    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_PERIOD   = 3'd4;

    // Register reset values.
    localparam logic [23:0] INTERVAL_LOW_RESET   = 24'd90000;
    localparam logic [23:0] INTERVAL_HIGH_RESET  = 24'd110000;
    localparam logic [9:0]  INTERVAL_FLOOR_RESET = 10'd1;
    localparam logic [3:0]  GOOD_NEEDED_RESET    = 4'd3;
    localparam logic [23:0] CHECK_PERIOD_RESET   = 24'd200000;

    typedef struct packed {
        logic [2:0] operation;
        logic       value;
    } item_t;

    typedef struct packed {
        logic [1:0] unit_state;
        logic       rate_ok;
    } result_t;

    typedef struct packed {
        logic [23:0] interval_low;
        logic [23:0] interval_high;
        logic [9:0]  interval_floor;
        logic [3:0]  good_needed;
        logic [23:0] check_period;
    } cfg_t;

endpackage

// ===== hdl/srhm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// srhm_cfg_regs
// Configuration register bank of the scan rate health monitor.
// ----------------------------------------------------------------------------
module srhm_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [srhm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srhm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output srhm_pkg::cfg_t                   cfg
);
    import srhm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INTERVAL_LOW:   cfg_next.interval_low   = cfg_data;
                REG_INTERVAL_HIGH:  cfg_next.interval_high  = cfg_data;
                REG_INTERVAL_FLOOR: cfg_next.interval_floor = cfg_data[9:0];
                REG_GOOD_NEEDED:    cfg_next.good_needed    = cfg_data[3:0];
                REG_CHECK_PERIOD:   cfg_next.check_period   = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_low   <= INTERVAL_LOW_RESET;
            cfg_reg.interval_high  <= INTERVAL_HIGH_RESET;
            cfg_reg.interval_floor <= INTERVAL_FLOOR_RESET;
            cfg_reg.good_needed    <= GOOD_NEEDED_RESET;
            cfg_reg.check_period   <= CHECK_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/scan_rate_health_monitor.sv =====
// ----------------------------------------------------------------------------
// scan_rate_health_monitor
// Latency: two register stages, the input register and the result register.
// A report is valid on the output once the tick that ends a check period has
// passed both. Throughput: one item per cycle; the input stalls only while a
// report waits in the result register under result stall. Reset: asynchronous,
// active low; clears monitor state and sets command on; loads register defaults.
// ----------------------------------------------------------------------------
module scan_rate_health_monitor
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  srhm_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output srhm_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [srhm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srhm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import srhm_pkg::*;

    cfg_t cfg;

    srhm_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register.
    logic    hold_valid_reg, hold_valid_next;
    item_t   hold_reg, hold_next;

    // Result register.
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    // Monitor state.
    logic [31:0] time_now_reg, time_now_next;
    logic [31:0] latest_arrival_reg, latest_arrival_next;
    logic [31:0] gap_reg, gap_next;
    logic        previous_valid_reg, previous_valid_next;
    logic        latest_valid_reg, latest_valid_next;
    logic        front_on_reg, front_on_next;
    logic        back_on_reg, back_on_next;
    logic        command_on_reg, command_on_next;
    logic [3:0]  good_count_reg, good_count_next;
    logic        ok_flag_reg, ok_flag_next;
    logic [23:0] period_count_reg, period_count_next;

    logic        advance;
    logic        emit;
    logic [23:0] period_inc;
    logic [23:0] period_limit;
    logic        gap_bad;
    logic [1:0]  unit_state;

    // The held item is processed whenever the result register can take a value.
    assign advance    = hold_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = hold_valid_reg && !advance;

    assign period_inc   = period_count_reg + 24'd1;
    assign period_limit = (cfg.check_period == 24'd0) ? 24'd1 : cfg.check_period;

    // The interval between the two latest arrivals is kept ready from the frame.
    assign gap_bad = (gap_reg < {22'd0, cfg.interval_floor})
                  || (gap_reg < {8'd0, cfg.interval_low})
                  || (gap_reg > {8'd0, cfg.interval_high});

    always_comb
    begin
        if (front_on_reg && back_on_reg)
        begin
            unit_state = UNIT_ON;
        end
        else if (!front_on_reg && !back_on_reg)
        begin
            unit_state = UNIT_OFF;
        end
        else
        begin
            unit_state = command_on_reg ? UNIT_STARTING : UNIT_STOPPING;
        end
    end

    always_comb
    begin
        hold_valid_next     = hold_valid_reg;
        hold_next           = hold_reg;
        result_valid_next   = result_valid_reg;
        result_next         = result_reg;
        time_now_next       = time_now_reg;
        latest_arrival_next = latest_arrival_reg;
        gap_next            = gap_reg;
        previous_valid_next = previous_valid_reg;
        latest_valid_next   = latest_valid_reg;
        front_on_next       = front_on_reg;
        back_on_next        = back_on_reg;
        command_on_next     = command_on_reg;
        good_count_next     = good_count_reg;
        ok_flag_next        = ok_flag_reg;
        period_count_next   = period_count_reg;
        emit                = 1'b0;

        if (!item_stall)
        begin
            hold_valid_next = item_valid;
            hold_next       = item;
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (advance)
        begin
            unique case (hold_reg.operation)
                OP_TICK:
                begin
                    time_now_next = time_now_reg + 32'd1;
                    if (period_inc >= period_limit)
                    begin
                        emit              = 1'b1;
                        period_count_next = 24'd0;
                        if (!front_on_reg || !back_on_reg)
                        begin
                            good_count_next = 4'd0;
                            ok_flag_next    = 1'b0;
                        end
                        else if (previous_valid_reg && latest_valid_reg)
                        begin
                            if (gap_bad)
                            begin
                                if (good_count_reg != 4'd0)
                                begin
                                    good_count_next = good_count_reg - 4'd1;
                                end
                                else
                                begin
                                    ok_flag_next = 1'b0;
                                end
                            end
                            else if (good_count_reg >= cfg.good_needed)
                            begin
                                ok_flag_next = 1'b1;
                            end
                            else
                            begin
                                good_count_next = good_count_reg + 4'd1;
                            end
                        end
                    end
                    else
                    begin
                        period_count_next = period_inc;
                    end
                end
                OP_FRAME:
                begin
                    if (hold_reg.value)
                    begin
                        gap_next            = time_now_reg - latest_arrival_reg;
                        previous_valid_next = latest_valid_reg;
                        latest_arrival_next = time_now_reg;
                        latest_valid_next   = 1'b1;
                    end
                end
                OP_FRONT:
                begin
                    front_on_next = hold_reg.value;
                end
                OP_BACK:
                begin
                    back_on_next = hold_reg.value;
                end
                OP_COMMAND:
                begin
                    command_on_next   = hold_reg.value;
                    ok_flag_next      = 1'b0;
                    good_count_next   = 4'd0;
                    latest_valid_next = 1'b0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase

            result_valid_next      = emit;
            result_next.unit_state = unit_state;
            result_next.rate_ok    = ok_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg     <= 1'b0;
            result_valid_reg   <= 1'b0;
            time_now_reg       <= 32'd0;
            latest_arrival_reg <= 32'd0;
            gap_reg            <= 32'd0;
            previous_valid_reg <= 1'b0;
            latest_valid_reg   <= 1'b0;
            front_on_reg       <= 1'b0;
            back_on_reg        <= 1'b0;
            command_on_reg     <= 1'b1;
            good_count_reg     <= 4'd0;
            ok_flag_reg        <= 1'b0;
            period_count_reg   <= 24'd0;
        end
        else
        begin
            hold_valid_reg     <= hold_valid_next;
            result_valid_reg   <= result_valid_next;
            time_now_reg       <= time_now_next;
            latest_arrival_reg <= latest_arrival_next;
            gap_reg            <= gap_next;
            previous_valid_reg <= previous_valid_next;
            latest_valid_reg   <= latest_valid_next;
            front_on_reg       <= front_on_next;
            back_on_reg        <= back_on_next;
            command_on_reg     <= command_on_next;
            good_count_reg     <= good_count_next;
            ok_flag_reg        <= ok_flag_next;
            period_count_reg   <= period_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
